@@ hw/rtl/dft_pkg.sv @@
// Shared constants and types for the DALI forward-frame transmitter.
package dft_pkg;

    // Frame layout
    localparam int unsigned FRAME_BITS   = 17;
    localparam int unsigned HALF_W       = 6;
    localparam logic [HALF_W-1:0] FRAME_HALVES = 6'd34;
    localparam logic [7:0]  ADDR_MAX     = 8'h3F;
    localparam logic [7:0]  FLAG_MAX     = 8'h01;

    // Configuration register defaults
    localparam logic [15:0] HALF_RESET   = 16'd416;

    // Configuration register indexes
    localparam logic REG_HALF_BIT_TICKS = 1'b0;
    localparam logic REG_ACTIVE_HIGH    = 1'b1;

    // Request status codes
    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_INVALID  = 2'd2,
        STATUS_BUSY     = 2'd3
    } req_status_t;

endpackage

@@ hw/rtl/dali_forward_frame_tx.sv @@
// DALI forward-frame Manchester transmitter, one tick item per clock while the output is not stalled.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | send_request, group_flag, target_address,
//           |                      | command_type, data_byte (one timer tick)
//  output   | out_valid / out_stall| tx_line, busy_res, request_status
//  config   | APB (psel, penable)  | 0x0 half_bit_ticks, 0x4 active_high
//
// The frame state and the result register are updated at the edge that accepts a
// tick item, so one item enters every clock unless the held result is stalled.
// The result register is the only buffer; the input stalls only while a held
// result is itself stalled. Reset clears the frame state to idle and loads the
// register defaults. A frame lasts 34 * max(half_bit_ticks, 1) accepted items.
module dali_forward_frame_tx #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        send_request,
    input  logic [7:0]  group_flag,
    input  logic [7:0]  target_address,
    input  logic [7:0]  command_type,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_line,
    output logic        busy_res,
    output logic [1:0]  request_status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dft_pkg::*;

    localparam int unsigned LIM_W = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;
    localparam logic [LIM_W-1:0] LIM_TOP = LIM_W'(1) << TIMER_WIDTH;
    localparam logic [LIM_W-1:0] LIM_ONE = LIM_W'(1);

    // Configuration registers
    logic [15:0]            half_ticks_reg;
    logic                   active_high_reg;

    // Frame state
    logic [FRAME_BITS-1:0]  shift_reg, shift_next;
    logic [HALF_W-1:0]      half_idx_reg, half_idx_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic                   sending_reg, sending_next;

    // Result register
    logic                   out_valid_reg;
    logic                   tx_line_reg, tx_line_next;
    logic                   busy_reg, busy_next;
    req_status_t            status_reg, status_next;

    logic                   in_accept;
    logic                   cfg_write;
    logic [LIM_W-1:0]       half_limit;
    logic [LIM_W-1:0]       tick_plus;
    logic [FRAME_BITS-1:0]  ld_shift;
    logic [HALF_W-1:0]      idx_inc;
    logic                   fields_bad;
    logic                   cur_bit;
    logic                   lvl;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign out_valid      = out_valid_reg;
    assign tx_line        = tx_line_reg;
    assign busy_res       = busy_reg;
    assign request_status = status_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_HALF_BIT_TICKS: prdata = {16'd0, half_ticks_reg};
            REG_ACTIVE_HIGH:    prdata = {31'd0, active_high_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_ticks_reg  <= HALF_RESET;
            active_high_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_HALF_BIT_TICKS)
                half_ticks_reg <= pwdata[15:0];
            else
                active_high_reg <= pwdata[0];
        end
    end

    // Clamp the half-bit length to 1 .. 2^TIMER_WIDTH
    always_comb
    begin
        half_limit = LIM_W'(half_ticks_reg);
        if (half_ticks_reg == 16'd0)
            half_limit = LIM_ONE;
        if (half_limit > LIM_TOP)
            half_limit = LIM_TOP;
    end

    // Build the frame: start bit, g,aaaaaa,c, data byte
    assign ld_shift   = {1'b1, group_flag[0], target_address[5:0], command_type[0], data_byte};
    assign fields_bad = (group_flag > FLAG_MAX) | (command_type > FLAG_MAX) |
                        (target_address > ADDR_MAX);

    // Tick step: take request, drive line, advance timer and half bit
    always_comb
    begin
        shift_next    = shift_reg;
        half_idx_next = half_idx_reg;
        tick_next     = tick_reg;
        sending_next  = sending_reg;
        status_next   = STATUS_NONE;

        if (send_request)
        begin
            if (sending_reg)
                status_next = STATUS_BUSY;
            else if (fields_bad)
                status_next = STATUS_INVALID;
            else
            begin
                shift_next    = ld_shift;
                half_idx_next = '0;
                tick_next     = '0;
                sending_next  = 1'b1;
                status_next   = STATUS_ACCEPTED;
            end
        end

        busy_next = sending_next;
        cur_bit   = shift_next[FRAME_BITS-1];
        lvl       = half_idx_next[0] ? cur_bit : ~cur_bit;
        if (sending_next)
            tx_line_next = lvl ^ active_high_reg;
        else
            tx_line_next = ~active_high_reg;

        tick_plus = LIM_W'(tick_next) + LIM_ONE;
        idx_inc   = half_idx_next + HALF_W'(1);
        if (sending_next)
        begin
            if (tick_plus >= half_limit)
            begin
                tick_next = '0;
                if (half_idx_next[0])
                    shift_next = {shift_next[FRAME_BITS-2:0], 1'b0};
                half_idx_next = idx_inc;
                if (idx_inc >= FRAME_HALVES)
                begin
                    sending_next  = 1'b0;
                    half_idx_next = '0;
                    shift_next    = '0;
                end
            end
            else
                tick_next = tick_plus[TIMER_WIDTH-1:0];
        end
    end

    // Advance frame state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            half_idx_reg <= '0;
            tick_reg     <= '0;
            sending_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            shift_reg    <= shift_next;
            half_idx_reg <= half_idx_next;
            tick_reg     <= tick_next;
            sending_reg  <= sending_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tx_line_reg <= tx_line_next;
            busy_reg    <= busy_next;
            status_reg  <= status_next;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the DALI forward-frame transmitter.
module tb_top;
    import dft_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned HOLD_EVERY     = 400;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned NUM_PHASES     = 7;
    localparam int unsigned PHASE_TICKS    = 105;

    typedef struct packed {
        logic       req;
        logic [7:0] grp;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] data;
    } tick_item_t;

    typedef struct packed {
        logic        line;
        logic        busy;
        req_status_t status;
    } line_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        send_request = 1'b0;
    logic [7:0]  group_flag = '0;
    logic [7:0]  target_address = '0;
    logic [7:0]  command_type = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        tx_line;
    logic        busy_res;
    logic [1:0]  request_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Encoder shadow state and register copies
    logic [16:0] frame_bits;
    logic [5:0]  half_idx;
    logic [15:0] half_ticks_done;
    logic        frame_active;
    logic [15:0] cfg_half_ticks;
    logic        cfg_active_high;

    tick_item_t   pending_ticks_q[$];
    line_sample_t line_expect_q[$];
    tick_item_t   cur_tick;
    int unsigned  send_gap_max = 7;
    int unsigned  rx_gap_max = 7;
    int unsigned  tx_wait = 0;
    int unsigned  rx_wait = 0;
    int unsigned  results_seen = 0;
    int unsigned  err_count = 0;
    int unsigned  idle_cycles = 0;

    int unsigned phase_half [NUM_PHASES] = '{1, 2, 3, 1, 0, 5, 2};
    logic        phase_pol  [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    int unsigned phase_txg  [NUM_PHASES] = '{7, 0, 7, 7, 0, 3, 7};
    int unsigned phase_rxg  [NUM_PHASES] = '{7, 0, 7, 0, 7, 3, 7};

    dali_forward_frame_tx DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .send_request   (send_request),
        .group_flag     (group_flag),
        .target_address (target_address),
        .command_type   (command_type),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_line        (tx_line),
        .busy_res       (busy_res),
        .request_status (request_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the encoder by one tick and return the line sample it produces
    function automatic line_sample_t encode_tick(tick_item_t it);
        line_sample_t s;
        logic [16:0]  limit;
        logic         bit_now;
        s.status = STATUS_NONE;
        if (it.req)
        begin
            if (frame_active)
                s.status = STATUS_BUSY;
            else if (it.grp > FLAG_MAX || it.cmd > FLAG_MAX || it.addr > ADDR_MAX)
                s.status = STATUS_INVALID;
            else
            begin
                frame_bits      = {1'b1, it.grp[0], it.addr[5:0], it.cmd[0], it.data};
                half_idx        = '0;
                half_ticks_done = '0;
                frame_active    = 1'b1;
                s.status        = STATUS_ACCEPTED;
            end
        end
        s.busy = frame_active;
        if (!frame_active)
            s.line = ~cfg_active_high;
        else
        begin
            // first half carries the inverted bit in active-low coding
            bit_now = frame_bits[FRAME_BITS-1];
            s.line  = (half_idx[0] ? bit_now : ~bit_now) ^ cfg_active_high;
        end
        if (frame_active)
        begin
            limit = (cfg_half_ticks == 16'd0) ? 17'd1 : {1'b0, cfg_half_ticks};
            if ({1'b0, half_ticks_done} + 17'd1 >= limit)
            begin
                half_ticks_done = '0;
                if (half_idx[0])
                    frame_bits = {frame_bits[15:0], 1'b0};
                half_idx = half_idx + 6'd1;
                if (half_idx >= FRAME_HALVES)
                begin
                    frame_active = 1'b0;
                    half_idx     = '0;
                    frame_bits   = '0;
                end
            end
            else
                half_ticks_done = half_ticks_done + 16'd1;
        end
        return s;
    endfunction

    function automatic void queue_tick(logic req, logic [7:0] g, logic [7:0] a,
                                       logic [7:0] c, logic [7:0] d);
        tick_item_t it;
        it.req  = req;
        it.grp  = g;
        it.addr = a;
        it.cmd  = c;
        it.data = d;
        pending_ticks_q.push_back(it);
    endfunction

    // Queue idle ticks with random payload
    function automatic void queue_idle(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_tick(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // Write one register over APB and mirror it in the shadow copy
    task automatic cfg_write(input logic idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HALF_BIT_TICKS)
            cfg_half_ticks = val[15:0];
        else
            cfg_active_high = val[0];
        @(negedge clk);
    endtask

    // Hold until every queued tick has been accepted and its sample checked
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ticks_q.size() != 0 || in_valid || line_expect_q.size() != 0);
    endtask

    // Mostly idle ticks, some well-formed requests, a few malformed ones
    task automatic run_random_phase(int unsigned n);
        tick_item_t  it;
        int unsigned roll;
        for (int unsigned i = 0; i < n; i++)
        begin
            roll    = $urandom_range(0, 99);
            it.data = 8'($urandom_range(0, 255));
            it.grp  = 8'($urandom_range(0, 1));
            it.addr = 8'($urandom_range(0, 63));
            it.cmd  = 8'($urandom_range(0, 1));
            it.req  = (roll < 7);
            if (roll < 2)
            begin
                case ($urandom_range(0, 2))
                    0: it.grp = 8'($urandom_range(2, 255));
                    1: it.addr = 8'($urandom_range(64, 255));
                    default: it.cmd = 8'($urandom_range(2, 255));
                endcase
            end
            else if (roll >= 7)
            begin
                it.grp  = 8'($urandom_range(0, 255));
                it.addr = 8'($urandom_range(0, 255));
                it.cmd  = 8'($urandom_range(0, 255));
            end
            pending_ticks_q.push_back(it);
        end
        wait_drained();
    endtask

    // Driver: present queued ticks, with a random gap after each item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            send_request   <= 1'b0;
            group_flag     <= '0;
            target_address <= '0;
            command_type   <= '0;
            data_byte      <= '0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                line_expect_q.push_back(encode_tick(cur_tick));
            if (!in_valid || !in_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait = tx_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks_q.size() > 0)
                begin
                    cur_tick = pending_ticks_q.pop_front();
                    send_request   <= cur_tick.req;
                    group_flag     <= cur_tick.grp;
                    target_address <= cur_tick.addr;
                    command_type   <= cur_tick.cmd;
                    data_byte      <= cur_tick.data;
                    in_valid       <= 1'b1;
                    tx_wait = $urandom_range(0, send_gap_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each line sample with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        line_sample_t exp_s;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (line_expect_q.size() == 0)
                begin
                    $error("unexpected line sample: tx_line %0d busy_res %0d status %0d",
                           tx_line, busy_res, request_status);
                    err_count++;
                end
                else
                begin
                    exp_s = line_expect_q.pop_front();
                    if (tx_line !== exp_s.line)
                    begin
                        $error("tx_line expected %0d actual %0d", exp_s.line, tx_line);
                        err_count++;
                    end
                    if (busy_res !== exp_s.busy)
                    begin
                        $error("busy_res expected %0d actual %0d", exp_s.busy, busy_res);
                        err_count++;
                    end
                    if (request_status !== exp_s.status)
                    begin
                        $error("request_status expected %0d actual %0d",
                               exp_s.status, request_status);
                        err_count++;
                    end
                end
                results_seen++;
                rx_wait = $urandom_range(0, rx_gap_max);
                // now and then hold off long enough to back up the input
                if (results_seen % HOLD_EVERY == 0)
                    rx_wait = HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        frame_bits      = '0;
        half_idx        = '0;
        half_ticks_done = '0;
        frame_active    = 1'b0;
        cfg_half_ticks  = HALF_RESET;
        cfg_active_high = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: start a frame, then requests while busy
        queue_tick(1'b1, 8'd1, 8'd63, 8'd1, 8'hFF);
        queue_idle(1);
        queue_tick(1'b1, 8'd0, 8'd5, 8'd0, 8'h12);
        queue_tick(1'b1, 8'd255, 8'd255, 8'd255, 8'h00);
        wait_drained();

        // Shorten the half bit mid-frame: counter is already past it
        cfg_write(REG_HALF_BIT_TICKS, 32'd1);
        cfg_write(REG_ACTIVE_HIGH, 32'd1);
        queue_idle(40);
        queue_tick(1'b1, 8'd2, 8'd0, 8'd0, 8'h00);
        queue_tick(1'b1, 8'd0, 8'd64, 8'd0, 8'h00);
        queue_tick(1'b1, 8'd0, 8'd0, 8'd2, 8'h00);
        queue_tick(1'b1, 8'd255, 8'd255, 8'd255, 8'hFF);
        queue_tick(1'b0, 8'd255, 8'd255, 8'd255, 8'hFF);
        queue_tick(1'b1, 8'd0, 8'd0, 8'd0, 8'h00);
        queue_idle(40);
        wait_drained();

        // Zero half-bit length; request on the last tick and the tick after
        cfg_write(REG_HALF_BIT_TICKS, 32'd0);
        cfg_write(REG_ACTIVE_HIGH, 32'd0);
        queue_tick(1'b1, 8'd0, 8'h2A, 8'd1, 8'h5A);
        queue_idle(32);
        queue_tick(1'b1, 8'd1, 8'h15, 8'd0, 8'hA5);
        queue_tick(1'b1, 8'd1, 8'h15, 8'd0, 8'hA5);
        queue_idle(40);
        wait_drained();

        // Longest half bit, then cut it short mid-frame
        cfg_write(REG_HALF_BIT_TICKS, 32'd65535);
        queue_tick(1'b1, 8'd1, 8'h15, 8'd0, 8'hC3);
        queue_idle(20);
        wait_drained();
        cfg_write(REG_HALF_BIT_TICKS, 32'd2);
        queue_idle(80);
        wait_drained();

        // Random phases over several settings
        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            cfg_write(REG_HALF_BIT_TICKS, phase_half[p]);
            cfg_write(REG_ACTIVE_HIGH, {31'd0, phase_pol[p]});
            send_gap_max = phase_txg[p];
            rx_gap_max   = phase_rxg[p];
            run_random_phase(PHASE_TICKS);
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && line_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
